FILE: rtl/assert_macros.svh
// Assertion macros used by the checker file.
// BKM_ASSERT needs clk_i and rst_ni in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of a named clock, off while in reset.
`define BKM_ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("balanced_kmeans_pass port check failed");

// Check a property on clk_i, off while rst_ni is low.
`define BKM_ASSERT(lbl, prop) \
  `BKM_ASSERT_CLK(lbl, clk_i, rst_ni, prop)

`endif

FILE: rtl/bkm_pkg.sv
// Shared widths, register indexes and controller/datapath command types
// for the balanced k-means pass. No dependencies.
package bkm_pkg;

  localparam int unsigned MaxClusters = 4;
  localparam int unsigned IdxW        = 2;
  localparam int unsigned CoordW      = 16;
  localparam int unsigned DemW        = 16;
  localparam int unsigned LoadW       = 26;
  localparam int unsigned SumW        = 27;
  localparam int unsigned CntW        = 11;
  localparam int unsigned NumW        = 3;
  localparam int unsigned SqW         = 32;
  localparam int unsigned DevW        = 27;
  localparam int unsigned ScoreW      = 56;
  localparam int unsigned DivSteps    = SumW;
  localparam int unsigned DivCntW     = 5;
  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned CfgDataW    = 32;
  localparam int unsigned InDataW     = 48;
  localparam int unsigned OutDataW    = 40;

  typedef enum logic [CfgIdxW-1:0] {
    CfgNumClusters = 3'd0,
    CfgTargetLoad  = 3'd1,
    CfgCenter0     = 3'd2,
    CfgCenter1     = 3'd3,
    CfgCenter2     = 3'd4,
    CfgCenter3     = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic            latch_pt;
    logic            square;
    logic            compare;
    logic            first;
    logic            update;
    logic            emit_asg;
    logic            div_start;
    logic            div_step;
    logic            emit_ctr;
    logic            last_res;
    logic            clear;
    logic [IdxW-1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic            out_free;
    logic            fin;
    logic            div_done;
    logic [IdxW-1:0] last_idx;
  } sts_t;

endpackage

FILE: rtl/bkm_ctrl.sv
// Sequencer for the balanced k-means pass: scoring, update and centre output.
// Depends on bkm_pkg.
module bkm_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  bkm_pkg::sts_t sts_i,
  output bkm_pkg::cmd_t cmd_o
);

  typedef enum logic [2:0] {
    SIdle, SSquare, SCompare, SUpdate, SDivStart, SDiv, SEmit
  } state_e;

  state_e state_q, state_d;
  logic [bkm_pkg::IdxW-1:0] k_q, k_d;

  always_comb begin
    state_d    = state_q;
    k_d        = k_q;
    cmd_o      = '0;
    cmd_o.idx  = k_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      SIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch_pt = 1'b1;
          k_d            = '0;
          state_d        = SSquare;
        end
      end
      SSquare: begin
        cmd_o.square = 1'b1;
        state_d      = SCompare;
      end
      SCompare: begin
        cmd_o.compare = 1'b1;
        cmd_o.first   = (k_q == '0);
        if (k_q == sts_i.last_idx) begin
          state_d = SUpdate;
        end else begin
          k_d     = k_q + 1'b1;
          state_d = SSquare;
        end
      end
      SUpdate: begin
        if (sts_i.out_free) begin
          cmd_o.update   = 1'b1;
          cmd_o.emit_asg = 1'b1;
          cmd_o.last_res = !sts_i.fin;
          k_d            = '0;
          state_d        = sts_i.fin ? SDivStart : SIdle;
        end
      end
      SDivStart: begin
        cmd_o.div_start = 1'b1;
        state_d         = SDiv;
      end
      SDiv: begin
        if (sts_i.div_done) state_d = SEmit;
        else cmd_o.div_step = 1'b1;
      end
      SEmit: begin
        if (sts_i.out_free) begin
          cmd_o.emit_ctr = 1'b1;
          cmd_o.last_res = (k_q == sts_i.last_idx);
          if (k_q == sts_i.last_idx) begin
            cmd_o.clear = 1'b1;
            state_d     = SIdle;
          end else begin
            k_d     = k_q + 1'b1;
            state_d = SDivStart;
          end
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
    end
  end

endmodule

FILE: rtl/bkm_dp.sv
// Datapath of the balanced k-means pass: config, cluster state, scorer,
// serial divider and output register. Depends on bkm_pkg.
module bkm_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bkm_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [bkm_pkg::CfgDataW-1:0]   cfg_data_i,
  input  logic [bkm_pkg::InDataW-1:0]    in_data_i,
  input  logic                           in_last_i,
  input  bkm_pkg::cmd_t                  cmd_i,
  output bkm_pkg::sts_t                  sts_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [bkm_pkg::OutDataW-1:0]   out_data_o,
  output logic                           out_kind_o,
  output logic                           out_last_o
);

  localparam int unsigned SumW  = bkm_pkg::SumW;
  localparam int unsigned CntW  = bkm_pkg::CntW;
  localparam int unsigned LoadW = bkm_pkg::LoadW;
  localparam int unsigned CW    = bkm_pkg::CoordW;
  localparam int unsigned IdxW  = bkm_pkg::IdxW;
  localparam int unsigned NC    = bkm_pkg::MaxClusters;

  function automatic logic [SumW-1:0] sat_sum(input logic signed [SumW:0] v);
    logic [SumW-1:0] r;
    if (v[SumW] != v[SumW-1]) r = v[SumW] ? {1'b1, {(SumW-1){1'b0}}}
                                          : {1'b0, {(SumW-1){1'b1}}};
    else r = v[SumW-1:0];
    return r;
  endfunction

  function automatic logic [CW-1:0] mean_out(input logic [SumW-1:0] q, input logic neg,
                                             input logic zero);
    logic [CW-1:0] r;
    if (zero) r = '0;
    else if (!neg) r = (q > SumW'(32767)) ? 16'h7fff : q[CW-1:0];
    else r = (q > SumW'(32768)) ? 16'h8000 : 16'(-q[CW-1:0]);
    return r;
  endfunction

  // Configuration
  logic [bkm_pkg::NumW-1:0] num_q;
  logic [LoadW-1:0]         tgt_q;
  logic [31:0]              ctr_q [NC];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q <= bkm_pkg::NumW'(NC);
      tgt_q <= '0;
      for (int i = 0; i < NC; i++) ctr_q[i] <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bkm_pkg::CfgNumClusters: num_q <= cfg_data_i[bkm_pkg::NumW-1:0];
        bkm_pkg::CfgTargetLoad:  tgt_q <= cfg_data_i[LoadW-1:0];
        bkm_pkg::CfgCenter0:     ctr_q[0] <= cfg_data_i;
        bkm_pkg::CfgCenter1:     ctr_q[1] <= cfg_data_i;
        bkm_pkg::CfgCenter2:     ctr_q[2] <= cfg_data_i;
        bkm_pkg::CfgCenter3:     ctr_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [IdxW-1:0] last_idx;
  always_comb begin
    if (num_q == '0) last_idx = '0;
    else if (num_q > bkm_pkg::NumW'(NC)) last_idx = IdxW'(NC - 1);
    else last_idx = IdxW'(num_q - 1'b1);
  end

  // Point latch
  logic signed [CW-1:0] px_q, py_q;
  logic [bkm_pkg::DemW-1:0] dem_q;
  logic fin_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_pt) begin
      px_q  <= in_data_i[15:0];
      py_q  <= in_data_i[31:16];
      dem_q <= in_data_i[47:32];
      fin_q <= in_last_i;
    end
  end

  // Cluster state
  logic [LoadW-1:0] load_q [NC];
  logic [SumW-1:0]  sx_q   [NC];
  logic [SumW-1:0]  sy_q   [NC];
  logic [CntW-1:0]  cnt_q  [NC];

  // Scorer: squares registered, then summed and compared
  logic signed [CW:0]        dx, dy;
  logic signed [2*CW+1:0]    dx2, dy2;
  logic [bkm_pkg::DevW-1:0]  after, dev;
  logic [bkm_pkg::SqW-1:0]   sqx_q, sqy_q;
  logic [2*bkm_pkg::DevW-1:0] dev2_q;
  logic [bkm_pkg::ScoreW-1:0] score, best_q;
  logic [IdxW-1:0]           bidx_q;

  assign dx    = (CW+1)'(px_q) - (CW+1)'($signed(ctr_q[cmd_i.idx][15:0]));
  assign dy    = (CW+1)'(py_q) - (CW+1)'($signed(ctr_q[cmd_i.idx][31:16]));
  assign dx2   = dx * dx;
  assign dy2   = dy * dy;
  assign after = bkm_pkg::DevW'(load_q[cmd_i.idx]) + bkm_pkg::DevW'(dem_q);
  assign dev   = (after >= bkm_pkg::DevW'(tgt_q)) ? after - bkm_pkg::DevW'(tgt_q)
                                                  : bkm_pkg::DevW'(tgt_q) - after;
  assign score = bkm_pkg::ScoreW'(sqx_q) + bkm_pkg::ScoreW'(sqy_q)
               + bkm_pkg::ScoreW'(dev2_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.square) begin
      sqx_q  <= dx2[bkm_pkg::SqW-1:0];
      sqy_q  <= dy2[bkm_pkg::SqW-1:0];
      dev2_q <= dev * dev;
    end
    if (cmd_i.compare && (cmd_i.first || score < best_q)) begin
      best_q <= score;
      bidx_q <= cmd_i.idx;
    end
  end

  // Accumulate into the winner, saturating
  logic [LoadW:0] nload;
  logic signed [SumW:0] nsx, nsy;
  assign nload = (LoadW+1)'(load_q[bidx_q]) + (LoadW+1)'(dem_q);
  assign nsx   = $signed({sx_q[bidx_q][SumW-1], sx_q[bidx_q]}) + (SumW+1)'(px_q);
  assign nsy   = $signed({sy_q[bidx_q][SumW-1], sy_q[bidx_q]}) + (SumW+1)'(py_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NC; i++) begin
        load_q[i] <= '0;
        sx_q[i]   <= '0;
        sy_q[i]   <= '0;
        cnt_q[i]  <= '0;
      end
    end else if (cmd_i.clear) begin
      for (int i = 0; i < NC; i++) begin
        load_q[i] <= '0;
        sx_q[i]   <= '0;
        sy_q[i]   <= '0;
        cnt_q[i]  <= '0;
      end
    end else if (cmd_i.update) begin
      load_q[bidx_q] <= nload[LoadW] ? {LoadW{1'b1}} : nload[LoadW-1:0];
      sx_q[bidx_q]   <= sat_sum(nsx);
      sy_q[bidx_q]   <= sat_sum(nsy);
      if (cnt_q[bidx_q] != {CntW{1'b1}}) cnt_q[bidx_q] <= cnt_q[bidx_q] + 1'b1;
    end
  end

  // Restoring divider, one quotient bit per cycle, x and y lanes side by side
  logic [SumW-1:0]  dvd_q [2];
  logic [CntW-1:0]  rem_q [2];
  logic             neg_q [2];
  logic [CntW-1:0]  den_q;
  logic [bkm_pkg::DivCntW-1:0] dcnt_q;
  logic [SumW-1:0]  src [2];
  logic [CntW:0]    rsh [2];

  assign src[0] = sx_q[cmd_i.idx];
  assign src[1] = sy_q[cmd_i.idx];

  always_comb begin
    for (int l = 0; l < 2; l++) rsh[l] = {rem_q[l], dvd_q[l][SumW-1]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dcnt_q <= '0;
    end else if (cmd_i.div_start) begin
      dcnt_q <= bkm_pkg::DivCntW'(bkm_pkg::DivSteps);
    end else if (cmd_i.div_step && dcnt_q != '0) begin
      dcnt_q <= dcnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      den_q <= cnt_q[cmd_i.idx];
      for (int l = 0; l < 2; l++) begin
        neg_q[l] <= src[l][SumW-1];
        dvd_q[l] <= src[l][SumW-1] ? SumW'(-src[l]) : src[l];
        rem_q[l] <= '0;
      end
    end else if (cmd_i.div_step && dcnt_q != '0) begin
      for (int l = 0; l < 2; l++) begin
        if (rsh[l] >= {1'b0, den_q}) begin
          rem_q[l] <= CntW'(rsh[l] - {1'b0, den_q});
          dvd_q[l] <= {dvd_q[l][SumW-2:0], 1'b1};
        end else begin
          rem_q[l] <= rsh[l][CntW-1:0];
          dvd_q[l] <= {dvd_q[l][SumW-2:0], 1'b0};
        end
      end
    end
  end

  // Output register
  logic            ov_q, okind_q, olast_q;
  logic [IdxW-1:0] ocl_q;
  logic [CW-1:0]   ocx_q, ocy_q;
  logic            out_free;

  assign out_free = !ov_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ov_q <= 1'b0;
    else if (cmd_i.emit_asg || cmd_i.emit_ctr) ov_q <= 1'b1;
    else if (out_ready_i) ov_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_asg) begin
      okind_q <= 1'b0;
      ocl_q   <= bidx_q;
      ocx_q   <= '0;
      ocy_q   <= '0;
      olast_q <= cmd_i.last_res;
    end else if (cmd_i.emit_ctr) begin
      okind_q <= 1'b1;
      ocl_q   <= cmd_i.idx;
      ocx_q   <= mean_out(dvd_q[0], neg_q[0], den_q == '0);
      ocy_q   <= mean_out(dvd_q[1], neg_q[1], den_q == '0);
      olast_q <= cmd_i.last_res;
    end
  end

  assign out_valid_o = ov_q;
  assign out_kind_o  = okind_q;
  assign out_last_o  = olast_q;
  assign out_data_o  = {6'd0, ocy_q, ocx_q, ocl_q};

  assign sts_o.out_free = out_free;
  assign sts_o.fin      = fin_q;
  assign sts_o.div_done = (dcnt_q == '0);
  assign sts_o.last_idx = last_idx;

endmodule

FILE: rtl/balanced_kmeans_pass.sv
// Top level of one balanced k-means assignment pass.
// Depends on bkm_pkg, bkm_ctrl and bkm_dp.
//
//  channel   dir  tdata (low bit up)                       tuser  tlast
//  s_axis    in   point_x[15:0] point_y[31:16] demand[47:32] -   last_point
//  m_axis    out  cluster[1:0] center_x[17:2] center_y[33:18] kind last
//  cfg       in   cfg_idx_i selects register, cfg_data_i[31:0], cfg_we_i strobe
//
// Each point is scored against the n clusters in use: one shared scorer forms
// the three squares for a cluster and adds and compares them in the next cycle.
// A final point then emits the centres, each with a load step, 27 divider steps
// of one quotient bit each, a step to see the divider done and an emit step.
// Reset is asynchronous and clears loads, sums and counts; no clearing pass.
// The output register holds a beat while m_axis_tready is low; the sequencer
// stalls only when it must load a new beat into an occupied register.
module balanced_kmeans_pass (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [bkm_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [bkm_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // point_x[15:0], point_y[31:16], demand[47:32]
  input  logic [bkm_pkg::InDataW-1:0]  s_axis_tdata,
  input  logic                         s_axis_tlast,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // cluster[1:0], center_x[17:2], center_y[33:18], zero pad
  output logic [bkm_pkg::OutDataW-1:0] m_axis_tdata,
  // kind[0]
  output logic                         m_axis_tuser,
  output logic                         m_axis_tlast
);

  bkm_pkg::cmd_t cmd;
  bkm_pkg::sts_t sts;

  // Sequence the scoring, the update and the centre beats
  bkm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Hold config, cluster state, scorer, divider and the output beat
  bkm_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (s_axis_tdata),
    .in_last_i   (s_axis_tlast),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_kind_o  (m_axis_tuser),
    .out_last_o  (m_axis_tlast)
  );

endmodule

FILE: rtl/bkm_checker.sv
// Port-level checks for balanced_kmeans_pass, bound to the top level.
// Depends on assert_macros.svh and bkm_pkg.
`include "assert_macros.svh"

module bkm_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tvalid,
  input logic                         s_axis_tready,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [bkm_pkg::OutDataW-1:0] m_axis_tdata,
  input logic                         m_axis_tuser
);

  // An assignment beat carries no centre
  `BKM_ASSERT(a_asg_zero, m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[33:2] == '0)

  // Scoring keeps the input closed in the cycle after a point is taken
  `BKM_ASSERT(a_busy, s_axis_tvalid && s_axis_tready |=> !s_axis_tready)

  // A stalled beat stays up
  `BKM_ASSERT(a_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)

endmodule

bind balanced_kmeans_pass bkm_checker u_bkm_checker (.*);
